/* hdl/bw_pkg.sv */
// bw_pkg: widths, word types and small arithmetic helpers for the
// barycentric weight block. No dependencies.
`default_nettype none
package bw_pkg;

  localparam int CoordW  = 16;
  localparam int WeightW = 24;
  localparam int WFrac   = 16;
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int CrossW  = ProdW + 1;
  localparam int MagW    = CrossW - 1;
  localparam int NumW    = MagW + WFrac;
  localparam int QBits   = WeightW + 1;
  localparam int WideW   = MagW + QBits;
  localparam int QDepth  = 2;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_a_x;
    logic signed [CoordW-1:0] vertex_a_y;
    logic signed [CoordW-1:0] vertex_b_x;
    logic signed [CoordW-1:0] vertex_b_y;
    logic signed [CoordW-1:0] vertex_c_x;
    logic signed [CoordW-1:0] vertex_c_y;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic signed [WeightW-1:0] weight_alpha;
    logic signed [WeightW-1:0] weight_beta;
    logic signed [WeightW-1:0] weight_gamma;
    logic                      degenerate;
  } out_word_t;

  typedef struct packed {
    logic signed [CrossW-1:0] area;
    logic signed [CrossW-1:0] num_a;
    logic signed [CrossW-1:0] num_b;
  } cross_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic signed [DiffW-1:0] diff_c(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b
  );
    return DiffW'(a) - DiffW'(b);
  endfunction

  function automatic logic signed [ProdW-1:0] mul_d(
    input logic signed [DiffW-1:0] a,
    input logic signed [DiffW-1:0] b
  );
    return ProdW'(a) * ProdW'(b);
  endfunction

  function automatic logic signed [CrossW-1:0] sub_p(
    input logic signed [ProdW-1:0] a,
    input logic signed [ProdW-1:0] b
  );
    return CrossW'(a) - CrossW'(b);
  endfunction

  function automatic logic [MagW-1:0] mag_x(input logic signed [CrossW-1:0] a);
    logic signed [CrossW-1:0] t;
    t = a[CrossW-1] ? -a : a;
    return t[MagW-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/bw_front.sv */
// bw_front: input register, edge differences, products and cross products.
// Depends on bw_pkg.
`default_nettype none
module bw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire bw_pkg::in_word_t  in_word,
  output logic                   push,
  output bw_pkg::cross_t         cross_word
);

  logic v1_r, v2_r, v3_r, v4_r;
  bw_pkg::in_word_t w_r;
  logic signed [bw_pkg::DiffW-1:0] cax_r, cay_r, bax_r, bay_r, cpx_r, cpy_r;
  logic signed [bw_pkg::DiffW-1:0] bpx_r, bpy_r, pax_r, pay_r;
  logic signed [bw_pkg::ProdW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  bw_pkg::cross_t x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_r <= in_word;
    end
    cax_r <= bw_pkg::diff_c(w_r.vertex_c_x, w_r.vertex_a_x);
    cay_r <= bw_pkg::diff_c(w_r.vertex_c_y, w_r.vertex_a_y);
    bax_r <= bw_pkg::diff_c(w_r.vertex_b_x, w_r.vertex_a_x);
    bay_r <= bw_pkg::diff_c(w_r.vertex_b_y, w_r.vertex_a_y);
    cpx_r <= bw_pkg::diff_c(w_r.vertex_c_x, w_r.point_x);
    cpy_r <= bw_pkg::diff_c(w_r.vertex_c_y, w_r.point_y);
    bpx_r <= bw_pkg::diff_c(w_r.vertex_b_x, w_r.point_x);
    bpy_r <= bw_pkg::diff_c(w_r.vertex_b_y, w_r.point_y);
    pax_r <= bw_pkg::diff_c(w_r.point_x, w_r.vertex_a_x);
    pay_r <= bw_pkg::diff_c(w_r.point_y, w_r.vertex_a_y);
    p1_r  <= bw_pkg::mul_d(cax_r, bay_r);
    p2_r  <= bw_pkg::mul_d(cay_r, bax_r);
    p3_r  <= bw_pkg::mul_d(cpx_r, bpy_r);
    p4_r  <= bw_pkg::mul_d(cpy_r, bpx_r);
    p5_r  <= bw_pkg::mul_d(cax_r, pay_r);
    p6_r  <= bw_pkg::mul_d(cay_r, pax_r);
    x_r.area  <= bw_pkg::sub_p(p1_r, p2_r);
    x_r.num_a <= bw_pkg::sub_p(p3_r, p4_r);
    x_r.num_b <= bw_pkg::sub_p(p5_r, p6_r);
  end

  assign push       = v4_r;
  assign cross_word = x_r;

endmodule
`default_nettype wire

/* hdl/bw_queue.sv */
// bw_queue: short FIFO of cross-product words between front and back.
// Depends on bw_pkg.
`default_nettype none
module bw_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire bw_pkg::cross_t      push_word,
  input  wire logic                pop,
  output bw_pkg::cross_t           pop_word,
  output bw_pkg::q_status_t        status
);

  localparam int PtrW = $clog2(bw_pkg::QDepth);

  bw_pkg::cross_t mem_r [bw_pkg::QDepth];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [PtrW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_word;
    end
  end

  assign pop_word     = mem_r[rd_r];
  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == (PtrW+1)'(bw_pkg::QDepth));

endmodule
`default_nettype wire

/* hdl/bw_div.sv */
// bw_div: pipelined restoring divider, one quotient bit per stage,
// saturating to the weight range. Depends on bw_pkg.
`default_nettype none
module bw_div (
  input  wire logic                               clk,
  input  wire logic [bw_pkg::NumW-1:0]            num,
  input  wire logic [bw_pkg::MagW-1:0]            den,
  input  wire logic                               neg,
  output logic signed [bw_pkg::WeightW-1:0]       quo
);

  localparam int QB = bw_pkg::QBits;
  localparam int WW = bw_pkg::WideW;

  logic [bw_pkg::NumW-1:0] rem_r [QB+1];
  logic [bw_pkg::MagW-1:0] d_r   [QB+1];
  logic [QB-1:0]           q_r   [QB+1];
  logic                    neg_r [QB+1];
  logic                    ovf_r [QB+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    d_r[0]   <= den;
    q_r[0]   <= '0;
    neg_r[0] <= neg;
    ovf_r[0] <= (WW'(num) >= {den, {QB{1'b0}}});
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [WW-1:0] dsh;
    logic          ge;
    assign dsh = WW'(d_r[k-1]) << (QB - k);
    assign ge  = WW'(rem_r[k-1]) >= dsh;
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_r[k-1] - dsh[bw_pkg::NumW-1:0] : rem_r[k-1];
      d_r[k]   <= d_r[k-1];
      q_r[k]   <= {q_r[k-1][QB-2:0], ge};
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  logic [QB-1:0] lim;
  logic [QB-1:0] qs;

  always_comb begin
    lim = neg_r[QB] ? (QB'(1) << (bw_pkg::WeightW - 1))
                    : ((QB'(1) << (bw_pkg::WeightW - 1)) - QB'(1));
    qs  = (ovf_r[QB] || (q_r[QB] > lim)) ? lim : q_r[QB];
    qs  = neg_r[QB] ? -qs : qs;
    quo = qs[bw_pkg::WeightW-1:0];
  end

endmodule
`default_nettype wire

/* hdl/bw_back.sv */
// bw_back: drains the queue, runs both divisions, forms gamma and the
// result register. Depends on bw_pkg and bw_div.
`default_nettype none
module bw_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bw_pkg::q_status_t   status,
  input  wire bw_pkg::cross_t      cross_word,
  output logic                     pop,
  output logic                     out_valid,
  output bw_pkg::out_word_t        out_word
);

  localparam int QB = bw_pkg::QBits;
  localparam int GW = bw_pkg::WeightW + 2;

  logic [QB:0] v_r;
  logic [QB:0] dg_r;
  logic        ov_r;
  bw_pkg::out_word_t ow_r;
  logic signed [bw_pkg::WeightW-1:0] qa, qb;
  logic [bw_pkg::MagW-1:0] mag_d, mag_a, mag_b;
  logic signed [GW-1:0] g;
  logic signed [bw_pkg::WeightW-1:0] gs;

  assign pop   = !status.empty;
  assign mag_d = bw_pkg::mag_x(cross_word.area);
  assign mag_a = bw_pkg::mag_x(cross_word.num_a);
  assign mag_b = bw_pkg::mag_x(cross_word.num_b);

  bw_div u_div_a (
    .clk (clk),
    .num ({mag_a, {bw_pkg::WFrac{1'b0}}}),
    .den (mag_d),
    .neg (cross_word.num_a[bw_pkg::CrossW-1] ^ cross_word.area[bw_pkg::CrossW-1]),
    .quo (qa)
  );

  bw_div u_div_b (
    .clk (clk),
    .num ({mag_b, {bw_pkg::WFrac{1'b0}}}),
    .den (mag_d),
    .neg (cross_word.num_b[bw_pkg::CrossW-1] ^ cross_word.area[bw_pkg::CrossW-1]),
    .quo (qb)
  );

  always_comb begin
    g = (GW'(1) << bw_pkg::WFrac) - GW'(qa) - GW'(qb);
    if (g > GW'((GW'(1) << (bw_pkg::WeightW - 1)) - GW'(1))) begin
      gs = {1'b0, {(bw_pkg::WeightW-1){1'b1}}};
    end else if (g < -(GW'(1) << (bw_pkg::WeightW - 1))) begin
      gs = {1'b1, {(bw_pkg::WeightW-1){1'b0}}};
    end else begin
      gs = g[bw_pkg::WeightW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      v_r  <= {v_r[QB-1:0], pop};
      ov_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    dg_r <= {dg_r[QB-1:0], (cross_word.area == '0)};
    if (dg_r[QB]) begin
      ow_r <= '{weight_alpha: '0, weight_beta: '0, weight_gamma: '0, degenerate: 1'b1};
    end else begin
      ow_r <= '{weight_alpha: qa, weight_beta: qb, weight_gamma: gs, degenerate: 1'b0};
    end
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule
`default_nettype wire

/* hdl/barycentric_weights.sv */
// barycentric_weights: top level joining front, queue and back.
// Words pass front, queue, dividers and output register; one accepted per cycle unless busy.
// Throughput is one word per cycle: the 25-stage divider pipelines take one quotient bit each.
// busy stays low in steady flow; the receiver cannot stall.
// Synchronous active-low reset clears all valid bits and the queue.
`default_nettype none
module barycentric_weights (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bw_pkg::in_word_t   in_word,
  output logic                    out_valid,
  output bw_pkg::out_word_t       out_word
);

  logic              push, pop;
  bw_pkg::cross_t    f_word, q_word;
  bw_pkg::q_status_t status;

  assign busy = status.full;

  bw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (start && !busy),
    .in_word    (in_word),
    .push       (push),
    .cross_word (f_word)
  );

  bw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (f_word),
    .pop       (pop),
    .pop_word  (q_word),
    .status    (status)
  );

  bw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .status     (status),
    .cross_word (q_word),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_word   (out_word)
  );

endmodule
`default_nettype wire
